// File: design/gda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gda_pkg;

  localparam int NUM_W = 26;
  localparam int CNT_W = 22;
  localparam logic [CNT_W-1:0] DAY_COUNT_MAX = '1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_STEP  = 7'b0000010,
    ST_CDAY  = 7'b0000100,
    ST_DIFF  = 7'b0001000,
    ST_TOTAL = 7'b0010000,
    ST_MONTH = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  // cycle sizes in years: 400, 100, 4, 1
  function automatic logic [NUM_W-1:0] year_unit(input logic [1:0] s);
    logic [NUM_W-1:0] v;
    unique case (s)
      2'd0: v = NUM_W'(400);
      2'd1: v = NUM_W'(100);
      2'd2: v = NUM_W'(4);
      2'd3: v = NUM_W'(1);
    endcase
    return v;
  endfunction

  // the same cycles in days
  function automatic logic [NUM_W-1:0] day_unit(input logic [1:0] s);
    logic [NUM_W-1:0] v;
    unique case (s)
      2'd0: v = NUM_W'(146097);
      2'd1: v = NUM_W'(36524);
      2'd2: v = NUM_W'(1461);
      2'd3: v = NUM_W'(365);
    endcase
    return v;
  endfunction

  // top quotient bit of each cycle stage
  function automatic logic [2:0] stage_top(input logic [1:0] s);
    logic [2:0] v;
    unique case (s)
      2'd0: v = 3'd7;
      2'd1: v = 3'd1;
      2'd2: v = 3'd4;
      2'd3: v = 3'd1;
    endcase
    return v;
  endfunction

  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] v;
    unique case (m)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] v;
    unique case (m)
      4'd1:                       v = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:    v = 5'd30;
      default:                    v = 5'd31;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: design/gda_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gda_req_if;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [4:0]        day_a;
  logic [3:0]        month_a;
  logic [13:0]       year_a;
  logic [4:0]        day_b;
  logic [3:0]        month_b;
  logic [13:0]       year_b;
  logic signed [22:0] offset_days;

  modport source (
    output valid, mode, day_a, month_a, year_a, day_b, month_b, year_b, offset_days,
    input  ready
  );
  modport sink (
    input  valid, mode, day_a, month_a, year_a, day_b, month_b, year_b, offset_days,
    output ready
  );
endinterface

`default_nettype wire

// File: design/gda_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gda_rsp_if;
  logic        valid;
  logic        ready;
  logic [21:0] day_count;
  logic [4:0]  res_day;
  logic [3:0]  res_month;
  logic [13:0] res_year;
  logic        out_of_range;

  modport source (
    output valid, day_count, res_day, res_month, res_year, out_of_range,
    input  ready
  );
  modport sink (
    input  valid, day_count, res_day, res_month, res_year, out_of_range,
    output ready
  );
endinterface

`default_nettype wire

// File: design/gregorian_date_arithmetic.sv
// Sequencing: mode 0 converts both dates through the shared restoring compare/subtract
// unit (17 steps per date conversion) and takes the difference; mode 1 converts date a,
// adds the offset and, if in range, converts back and walks the months (up to 12 steps).
// Throughput: one request at a time; the next is taken once the sequencer is back in idle.
// Reset: synchronous, active high; clears the sequencer and the result valid.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_arithmetic
  import gda_pkg::*;
#(
  parameter int MAX_YEAR = 9999
) (
  input  logic      clk,
  input  logic      rst,
  gda_req_if.sink   req,
  gda_rsp_if.source rsp
);

  localparam int LAST_INT = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;
  localparam logic [NUM_W:0] LAST_NUM = (NUM_W + 1)'(LAST_INT);

  state_t state;

  logic              mode_r;
  logic [4:0]        day_a_r, day_b_r;
  logic [3:0]        month_a_r, month_b_r;
  logic [13:0]       year_b_r;
  logic signed [22:0] off_r;

  logic              second, dir, yzero, oor;
  logic [1:0]        stage;
  logic [2:0]        bitk;
  logic [NUM_W-1:0]  rem, acc, a_num;
  logic [1:0]        q100, q1;
  logic [4:0]        q4;
  logic [3:0]        month;

  logic              out_valid;
  logic [CNT_W-1:0]  day_count_r;
  logic [4:0]        res_day_r;
  logic [3:0]        res_month_r;
  logic [13:0]       res_year_r;
  logic              oor_out_r;

  logic [NUM_W-1:0]  unit_d, unit_w, trial;
  logic              fits, leap, step_last, slot_free, range_bad, month_stop;
  logic [4:0]        cur_d;
  logic [3:0]        cur_m, mm_idx;
  logic [13:0]       start_y;
  logic [NUM_W-1:0]  num_done, diff;
  logic signed [NUM_W:0] tm1;
  logic [5:0]        mlen;
  logic [NUM_W-1:0]  year_p1;

  assign req.ready = (state == ST_IDLE);

  assign rsp.valid        = out_valid;
  assign rsp.day_count    = day_count_r;
  assign rsp.res_day      = res_day_r;
  assign rsp.res_month    = res_month_r;
  assign rsp.res_year     = res_year_r;
  assign rsp.out_of_range = oor_out_r;

  always_comb begin
    unit_d    = dir ? day_unit(stage) : year_unit(stage);
    unit_w    = dir ? year_unit(stage) : day_unit(stage);
    trial     = unit_d << bitk;
    fits      = (rem >= trial);
    step_last = (bitk == 3'd0) && (stage == 2'd3);
    leap      = yzero | ((q1 == 2'd3) && ((q4 != 5'd24) || (q100 == 2'd3)));

    cur_d   = second ? day_b_r : day_a_r;
    cur_m   = second ? month_b_r : month_a_r;
    start_y = (state == ST_IDLE) ? req.year_a : year_b_r;

    if (cur_m == 4'd0) begin
      mm_idx = 4'd0;
    end else if (cur_m > 4'd12) begin
      mm_idx = 4'd11;
    end else begin
      mm_idx = cur_m - 4'd1;
    end
    num_done = acc + NUM_W'(cum_days(mm_idx)) + NUM_W'(cur_d)
             + NUM_W'(leap && (mm_idx >= 4'd2));

    if (a_num >= acc) begin
      diff = a_num - acc;
    end else begin
      diff = acc - a_num;
    end

    tm1       = $signed({1'b0, acc}) + (NUM_W + 1)'(off_r) - (NUM_W + 1)'(1);
    range_bad = tm1[NUM_W] || ($unsigned(tm1) >= LAST_NUM);

    mlen       = 6'(month_len(month)) + 6'(leap && (month == 4'd1));
    month_stop = (month == 4'd11) || (rem < NUM_W'(mlen));

    slot_free = !out_valid || rsp.ready;
    year_p1   = acc + NUM_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_FIN && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (step_last) begin
            state <= dir ? ST_MONTH : ST_CDAY;
          end
        end
        ST_CDAY: begin
          if (!mode_r && !second) begin
            state <= ST_STEP;
          end else if (!mode_r) begin
            state <= ST_DIFF;
          end else begin
            state <= ST_TOTAL;
          end
        end
        ST_DIFF: state <= ST_FIN;
        ST_TOTAL: begin
          state <= range_bad ? ST_FIN : ST_STEP;
        end
        ST_MONTH: begin
          if (month_stop) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          mode_r    <= req.mode;
          day_a_r   <= req.day_a;
          month_a_r <= req.month_a;
          day_b_r   <= req.day_b;
          month_b_r <= req.month_b;
          year_b_r  <= req.year_b;
          off_r     <= req.offset_days;
          second    <= 1'b0;
          oor       <= 1'b0;
          rem       <= (start_y == 14'd0) ? '0 : NUM_W'(start_y - 14'd1);
          yzero     <= (start_y == 14'd0);
          acc       <= '0;
          q100      <= '0;
          q4        <= '0;
          q1        <= '0;
          dir       <= 1'b0;
          stage     <= 2'd0;
          bitk      <= stage_top(2'd0);
        end
      end
      ST_STEP: begin
        if (fits) begin
          rem <= rem - trial;
          acc <= acc + (unit_w << bitk);
        end
        unique case (stage)
          2'd0: ;
          2'd1: q100 <= {q100[0], fits};
          2'd2: q4   <= {q4[3:0], fits};
          2'd3: q1   <= {q1[0], fits};
        endcase
        if (bitk == 3'd0) begin
          stage <= stage + 2'd1;
          bitk  <= stage_top(stage + 2'd1);
        end else begin
          bitk <= bitk - 3'd1;
        end
      end
      ST_CDAY: begin
        if (!mode_r && !second) begin
          a_num  <= num_done;
          second <= 1'b1;
          rem    <= (start_y == 14'd0) ? '0 : NUM_W'(start_y - 14'd1);
          yzero  <= (start_y == 14'd0);
          acc    <= '0;
          q100   <= '0;
          q4     <= '0;
          q1     <= '0;
          dir    <= 1'b0;
          stage  <= 2'd0;
          bitk   <= stage_top(2'd0);
        end else begin
          acc <= num_done;
        end
      end
      ST_DIFF: begin
        acc <= (diff > NUM_W'(DAY_COUNT_MAX)) ? NUM_W'(DAY_COUNT_MAX) : diff;
      end
      ST_TOTAL: begin
        oor   <= range_bad;
        rem   <= tm1[NUM_W-1:0];
        acc   <= '0;
        q100  <= '0;
        q4    <= '0;
        q1    <= '0;
        yzero <= 1'b0;
        dir   <= 1'b1;
        stage <= 2'd0;
        bitk  <= stage_top(2'd0);
        month <= 4'd0;
      end
      ST_MONTH: begin
        if (!month_stop) begin
          rem   <= rem - NUM_W'(mlen);
          month <= month + 4'd1;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          oor_out_r <= mode_r & oor;
          if (!mode_r) begin
            day_count_r <= acc[CNT_W-1:0];
            res_day_r   <= '0;
            res_month_r <= '0;
            res_year_r  <= '0;
          end else if (oor) begin
            day_count_r <= '0;
            res_day_r   <= '0;
            res_month_r <= '0;
            res_year_r  <= '0;
          end else begin
            day_count_r <= '0;
            res_day_r   <= rem[4:0] + 5'd1;
            res_month_r <= month + 4'd1;
            res_year_r  <= year_p1[13:0];
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
